### hdl/ibhq_pkg.sv
package ibhq_pkg;

  localparam int TAG_BITS  = 6;
  localparam int TAG_COUNT = 64;
  localparam int CNT_OUT_BITS = 7;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_INC    = 3'd2;
  localparam logic [2:0] OP_DEC    = 3'd3;
  localparam logic [2:0] OP_POP    = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_NOTPRES = 3'd3;
  localparam logic [2:0] ST_DUP     = 3'd4;

  localparam logic REG_MIN_ORDER = 1'b0;
  localparam logic REG_CAPACITY  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_GETI, S_GETV, S_POPT, S_LASTD,
    S_UP, S_UPC, S_DN, S_DNL, S_DNR, S_WR, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    RS_ZERO, RS_SOT, RS_LAST, RS_PARENT, RS_LEFT, RS_RIGHT
  } rsel_t;

  typedef struct packed {
    logic       accept;
    logic       set_st;
    logic [2:0] st;
    logic       ins;
    logic       load_idx;
    logic       del;
    logic       modify;
    logic       pop;
    logic       load_last;
    logic       keep_left;
    logic       pick_right;
    logic       up_swap;
    logic       dn_swap;
    logic       wr_cur;
    logic       res_load;
    rsel_t      rsel;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       present;
    logic       empty;
    logic       idx_zero;
    logic       swap_up;
    logic       has_child;
    logic       has_right;
    logic       swap_dn;
    logic       at_end;
    logic       moved;
  } stat_t;

endpackage

### hdl/indexed_binary_heap_queue_core.sv
// Flow: a rejected item goes from decode straight to its result. A change adds a tag or
// last-entry lookup (none for insert), a parent read and compare per level moved up, a
// left-child read and, if there is one, a right-child read per level moved down, and a
// write-back before the result (none when the removed entry was the last one). One item in
// flight: the next item can be accepted in the cycle after the result is set.
// Reset (rst_n low, synchronous) empties the heap and clears all tag-present bits;
// min_order resets to 0 and capacity to 64. No clearing pass is needed.
module indexed_binary_heap_queue_core #(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_op,
  input  logic [ibhq_pkg::TAG_BITS-1:0]     in_tag,
  input  logic [31:0]                       in_amount,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_status,
  output logic [ibhq_pkg::TAG_BITS-1:0]     out_top_tag,
  output logic [ibhq_pkg::CNT_OUT_BITS-1:0] out_count,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic                              min_order_r, min_order_nxt;
  logic [ibhq_pkg::CNT_OUT_BITS-1:0] capacity_r, capacity_nxt;
  ibhq_pkg::cmd_t  cmd;
  ibhq_pkg::stat_t stat;

  assign pready = 1'b1;

  always_comb begin
    min_order_nxt = min_order_r;
    capacity_nxt  = capacity_r;
    if (psel && penable && pwrite) begin
      case (paddr[2])
        ibhq_pkg::REG_MIN_ORDER: min_order_nxt = pwdata[0];
        ibhq_pkg::REG_CAPACITY:  capacity_nxt  = pwdata[ibhq_pkg::CNT_OUT_BITS-1:0];
        default:                 min_order_nxt = min_order_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ibhq_pkg::REG_MIN_ORDER: prdata = {31'd0, min_order_r};
      ibhq_pkg::REG_CAPACITY:  prdata = 32'(capacity_r);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_order_r <= 1'b0;
      capacity_r  <= ibhq_pkg::CNT_OUT_BITS'(64);
    end else begin
      min_order_r <= min_order_nxt;
      capacity_r  <= capacity_nxt;
    end
  end

  ibhq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ibhq_dp #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_op       (in_op),
    .in_tag      (in_tag),
    .in_amount   (in_amount),
    .min_order   (min_order_r),
    .capacity    (capacity_r),
    .cmd         (cmd),
    .stat        (stat),
    .out_status  (out_status),
    .out_top_tag (out_top_tag),
    .out_count   (out_count)
  );

endmodule

### hdl/ibhq_ram.sv
module ibhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/ibhq_ctrl.sv
module ibhq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  ibhq_pkg::stat_t stat,
  output ibhq_pkg::cmd_t  cmd
);

  ibhq_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic sink_ok;

  assign in_ready  = (state_r == ibhq_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  // insert only rises; every other change sinks when it did not rise
  assign sink_ok   = !stat.moved && (stat.op != ibhq_pkg::OP_INSERT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ibhq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ibhq_pkg::S_IDLE: begin
        if (accept) state_nxt = ibhq_pkg::S_DECODE;
      end
      ibhq_pkg::S_DECODE: begin
        case (stat.op)
          ibhq_pkg::OP_INSERT: begin
            if (stat.full || stat.present) state_nxt = ibhq_pkg::S_FIN;
            else state_nxt = ibhq_pkg::S_UP;
          end
          ibhq_pkg::OP_DELETE, ibhq_pkg::OP_INC, ibhq_pkg::OP_DEC: begin
            if (!stat.present) state_nxt = ibhq_pkg::S_FIN;
            else state_nxt = ibhq_pkg::S_GETI;
          end
          ibhq_pkg::OP_POP: begin
            if (stat.empty) state_nxt = ibhq_pkg::S_FIN;
            else state_nxt = ibhq_pkg::S_POPT;
          end
          default: state_nxt = ibhq_pkg::S_FIN;
        endcase
      end
      ibhq_pkg::S_GETI: begin
        if (stat.op == ibhq_pkg::OP_DELETE) state_nxt = ibhq_pkg::S_LASTD;
        else state_nxt = ibhq_pkg::S_GETV;
      end
      ibhq_pkg::S_GETV:  state_nxt = ibhq_pkg::S_UP;
      ibhq_pkg::S_POPT:  state_nxt = ibhq_pkg::S_LASTD;
      ibhq_pkg::S_LASTD: begin
        if (stat.at_end) state_nxt = ibhq_pkg::S_FIN;
        else state_nxt = ibhq_pkg::S_UP;
      end
      ibhq_pkg::S_UP: begin
        if (!stat.idx_zero) state_nxt = ibhq_pkg::S_UPC;
        else if (sink_ok) state_nxt = ibhq_pkg::S_DN;
        else state_nxt = ibhq_pkg::S_WR;
      end
      ibhq_pkg::S_UPC: begin
        if (stat.swap_up) state_nxt = ibhq_pkg::S_UP;
        else if (sink_ok) state_nxt = ibhq_pkg::S_DN;
        else state_nxt = ibhq_pkg::S_WR;
      end
      ibhq_pkg::S_DN: begin
        if (stat.has_child) state_nxt = ibhq_pkg::S_DNL;
        else state_nxt = ibhq_pkg::S_WR;
      end
      ibhq_pkg::S_DNL: begin
        if (stat.has_right) state_nxt = ibhq_pkg::S_DNR;
        else if (stat.swap_dn) state_nxt = ibhq_pkg::S_DN;
        else state_nxt = ibhq_pkg::S_WR;
      end
      ibhq_pkg::S_DNR: begin
        if (stat.swap_dn) state_nxt = ibhq_pkg::S_DN;
        else state_nxt = ibhq_pkg::S_WR;
      end
      ibhq_pkg::S_WR: state_nxt = ibhq_pkg::S_FIN;
      ibhq_pkg::S_FIN: begin
        if (!out_valid_r || out_ready) state_nxt = ibhq_pkg::S_IDLE;
      end
      default: state_nxt = ibhq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rsel = ibhq_pkg::RS_ZERO;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.accept = accept;
    case (state_r)
      ibhq_pkg::S_DECODE: begin
        case (stat.op)
          ibhq_pkg::OP_INSERT: begin
            if (stat.full) begin
              cmd.set_st = 1'b1;
              cmd.st     = ibhq_pkg::ST_FULL;
            end else if (stat.present) begin
              cmd.set_st = 1'b1;
              cmd.st     = ibhq_pkg::ST_DUP;
            end else begin
              cmd.ins = 1'b1;
            end
          end
          ibhq_pkg::OP_DELETE, ibhq_pkg::OP_INC, ibhq_pkg::OP_DEC: begin
            if (!stat.present) begin
              cmd.set_st = 1'b1;
              cmd.st     = ibhq_pkg::ST_NOTPRES;
            end
          end
          ibhq_pkg::OP_POP: begin
            if (stat.empty) begin
              cmd.set_st = 1'b1;
              cmd.st     = ibhq_pkg::ST_EMPTY;
            end
            cmd.rsel = ibhq_pkg::RS_ZERO;
          end
          default: cmd.set_st = 1'b0;
        endcase
      end
      ibhq_pkg::S_GETI: begin
        cmd.load_idx = 1'b1;
        if (stat.op == ibhq_pkg::OP_DELETE) begin
          cmd.del  = 1'b1;
          cmd.rsel = ibhq_pkg::RS_LAST;
        end else begin
          cmd.rsel = ibhq_pkg::RS_SOT;
        end
      end
      ibhq_pkg::S_GETV: cmd.modify = 1'b1;
      ibhq_pkg::S_POPT: begin
        cmd.pop  = 1'b1;
        cmd.rsel = ibhq_pkg::RS_LAST;
      end
      ibhq_pkg::S_LASTD: begin
        if (!stat.at_end) cmd.load_last = 1'b1;
      end
      ibhq_pkg::S_UP: cmd.rsel = ibhq_pkg::RS_PARENT;
      ibhq_pkg::S_UPC: begin
        if (stat.swap_up) cmd.up_swap = 1'b1;
      end
      ibhq_pkg::S_DN: cmd.rsel = ibhq_pkg::RS_LEFT;
      ibhq_pkg::S_DNL: begin
        if (stat.has_right) begin
          cmd.keep_left = 1'b1;
          cmd.rsel      = ibhq_pkg::RS_RIGHT;
        end else if (stat.swap_dn) begin
          cmd.dn_swap = 1'b1;
        end
      end
      ibhq_pkg::S_DNR: begin
        cmd.pick_right = 1'b1;
        if (stat.swap_dn) cmd.dn_swap = 1'b1;
      end
      ibhq_pkg::S_WR: cmd.wr_cur = 1'b1;
      ibhq_pkg::S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd.set_st = 1'b0;
    endcase
  end

endmodule

### hdl/ibhq_dp.sv
module ibhq_dp #(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [2:0]                         in_op,
  input  logic [ibhq_pkg::TAG_BITS-1:0]      in_tag,
  input  logic [31:0]                        in_amount,
  input  logic                               min_order,
  input  logic [ibhq_pkg::CNT_OUT_BITS-1:0]  capacity,
  input  ibhq_pkg::cmd_t                     cmd,
  output ibhq_pkg::stat_t                    stat,
  output logic [2:0]                         out_status,
  output logic [ibhq_pkg::TAG_BITS-1:0]      out_top_tag,
  output logic [ibhq_pkg::CNT_OUT_BITS-1:0]  out_count
);

  localparam int TB = ibhq_pkg::TAG_BITS;
  localparam int VB = VALUE_BITS;
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = CW + 1;
  localparam int KW = (CW > ibhq_pkg::CNT_OUT_BITS) ? CW : ibhq_pkg::CNT_OUT_BITS;
  localparam int SW = VB + TB;

  logic [2:0]    op_r, op_nxt;
  logic [TB-1:0] tag_r, tag_nxt;
  logic [VB-1:0] amt_r, amt_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [VB-1:0] cur_val_r, cur_val_nxt, left_val_r, left_val_nxt;
  logic [TB-1:0] cur_tag_r, cur_tag_nxt, left_tag_r, left_tag_nxt;
  logic          moved_r, moved_nxt;
  logic [TB-1:0] top_r, top_nxt;
  logic [2:0]    st_r, st_nxt;
  logic [ibhq_pkg::TAG_COUNT-1:0] present_r, present_nxt;
  logic [2:0]    res_st_r, res_st_nxt;
  logic [TB-1:0] res_top_r, res_top_nxt;
  logic [ibhq_pkg::CNT_OUT_BITS-1:0] res_cnt_r, res_cnt_nxt;

  logic          slot_we, sot_we;
  logic [IW-1:0] slot_waddr, slot_raddr, sot_wdata, sot_rdata;
  logic [SW-1:0] slot_wdata, slot_rdata;
  logic [TB-1:0] sot_waddr;
  logic [VB-1:0] rd_val, ch_val;
  logic [TB-1:0] rd_tag, ch_tag;
  logic [IW-1:0] parent_idx, left_idx, right_idx, ch_idx, last_idx;
  logic [EW-1:0] left_e, right_e;
  logic          rgt_wins;

  function automatic logic below(input logic [VB-1:0] a, input logic [VB-1:0] b,
                                 input logic mo);
    below = mo ? (a > b) : (a < b);
  endfunction

  assign rd_val     = slot_rdata[VB-1:0];
  assign rd_tag     = slot_rdata[VB +: TB];
  assign parent_idx = IW'((idx_r - 1'b1) >> 1);
  assign left_e     = EW'({idx_r, 1'b1});
  assign right_e    = left_e + 1'b1;
  assign left_idx   = left_e[IW-1:0];
  assign right_idx  = right_e[IW-1:0];
  assign last_idx   = IW'(cnt_r - 1'b1);
  assign rgt_wins   = below(left_val_r, rd_val, min_order);

  always_comb begin
    if (cmd.pick_right && rgt_wins) begin
      ch_val = rd_val;
      ch_tag = rd_tag;
      ch_idx = right_idx;
    end else if (cmd.pick_right) begin
      ch_val = left_val_r;
      ch_tag = left_tag_r;
      ch_idx = left_idx;
    end else begin
      ch_val = rd_val;
      ch_tag = rd_tag;
      ch_idx = left_idx;
    end
  end

  always_comb begin
    case (cmd.rsel)
      ibhq_pkg::RS_ZERO:   slot_raddr = '0;
      ibhq_pkg::RS_SOT:    slot_raddr = sot_rdata;
      ibhq_pkg::RS_LAST:   slot_raddr = last_idx;
      ibhq_pkg::RS_PARENT: slot_raddr = parent_idx;
      ibhq_pkg::RS_LEFT:   slot_raddr = left_idx;
      ibhq_pkg::RS_RIGHT:  slot_raddr = right_idx;
      default:             slot_raddr = '0;
    endcase
  end

  always_comb begin
    slot_we    = 1'b0;
    sot_we     = 1'b0;
    slot_waddr = idx_r;
    sot_wdata  = idx_r;
    slot_wdata = {cur_tag_r, cur_val_r};
    sot_waddr  = cur_tag_r;
    if (cmd.up_swap) begin
      slot_we    = 1'b1;
      sot_we     = 1'b1;
      slot_wdata = slot_rdata;
      sot_waddr  = rd_tag;
    end else if (cmd.dn_swap) begin
      slot_we    = 1'b1;
      sot_we     = 1'b1;
      slot_wdata = {ch_tag, ch_val};
      sot_waddr  = ch_tag;
    end else if (cmd.wr_cur) begin
      slot_we = 1'b1;
      sot_we  = 1'b1;
    end
  end

  always_comb begin
    op_nxt       = op_r;
    tag_nxt      = tag_r;
    amt_nxt      = amt_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    cur_val_nxt  = cur_val_r;
    cur_tag_nxt  = cur_tag_r;
    left_val_nxt = left_val_r;
    left_tag_nxt = left_tag_r;
    moved_nxt    = moved_r;
    top_nxt      = top_r;
    st_nxt       = st_r;
    present_nxt  = present_r;
    res_st_nxt   = res_st_r;
    res_top_nxt  = res_top_r;
    res_cnt_nxt  = res_cnt_r;
    if (cmd.accept) begin
      op_nxt    = in_op;
      tag_nxt   = in_tag;
      amt_nxt   = VB'(in_amount);
      moved_nxt = 1'b0;
      top_nxt   = '0;
      st_nxt    = ibhq_pkg::ST_OK;
    end
    if (cmd.set_st) st_nxt = cmd.st;
    if (cmd.ins) begin
      idx_nxt             = IW'(cnt_r);
      cnt_nxt             = cnt_r + 1'b1;
      cur_val_nxt         = amt_r;
      cur_tag_nxt         = tag_r;
      present_nxt[tag_r]  = 1'b1;
    end
    if (cmd.load_idx) idx_nxt = sot_rdata;
    if (cmd.del) begin
      cnt_nxt            = cnt_r - 1'b1;
      present_nxt[tag_r] = 1'b0;
    end
    if (cmd.pop) begin
      top_nxt             = rd_tag;
      present_nxt[rd_tag] = 1'b0;
      cnt_nxt             = cnt_r - 1'b1;
      idx_nxt             = '0;
    end
    if (cmd.modify) begin
      cur_tag_nxt = rd_tag;
      if (op_r == ibhq_pkg::OP_INC) cur_val_nxt = rd_val + amt_r;
      else if (rd_val > amt_r) cur_val_nxt = rd_val - amt_r;
      else cur_val_nxt = '0;
    end
    if (cmd.load_last) begin
      cur_val_nxt = rd_val;
      cur_tag_nxt = rd_tag;
    end
    if (cmd.keep_left) begin
      left_val_nxt = rd_val;
      left_tag_nxt = rd_tag;
    end
    if (cmd.up_swap) begin
      idx_nxt   = parent_idx;
      moved_nxt = 1'b1;
    end
    if (cmd.dn_swap) idx_nxt = ch_idx;
    if (cmd.res_load) begin
      res_st_nxt  = st_r;
      res_top_nxt = top_r;
      res_cnt_nxt = ibhq_pkg::CNT_OUT_BITS'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      present_r <= '0;
    end else begin
      cnt_r     <= cnt_nxt;
      present_r <= present_nxt;
    end
    op_r       <= op_nxt;
    tag_r      <= tag_nxt;
    amt_r      <= amt_nxt;
    idx_r      <= idx_nxt;
    cur_val_r  <= cur_val_nxt;
    cur_tag_r  <= cur_tag_nxt;
    left_val_r <= left_val_nxt;
    left_tag_r <= left_tag_nxt;
    moved_r    <= moved_nxt;
    top_r      <= top_nxt;
    st_r       <= st_nxt;
    res_st_r   <= res_st_nxt;
    res_top_r  <= res_top_nxt;
    res_cnt_r  <= res_cnt_nxt;
  end

  assign stat.op        = op_r;
  assign stat.full      = (KW'(cnt_r) >= KW'(capacity)) || (cnt_r == CW'(DEPTH));
  assign stat.present   = present_r[tag_r];
  assign stat.empty     = (cnt_r == '0);
  assign stat.idx_zero  = (idx_r == '0);
  assign stat.swap_up   = below(rd_val, cur_val_r, min_order);
  assign stat.has_child = left_e < EW'(cnt_r);
  assign stat.has_right = right_e < EW'(cnt_r);
  assign stat.swap_dn   = below(cur_val_r, ch_val, min_order);
  assign stat.at_end    = (CW'(idx_r) == cnt_r);
  assign stat.moved     = moved_r;

  assign out_status  = res_st_r;
  assign out_top_tag = res_top_r;
  assign out_count   = res_cnt_r;

  ibhq_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  ibhq_ram #(.WIDTH(IW), .DEPTH(ibhq_pkg::TAG_COUNT)) u_sot_ram (
    .clk   (clk),
    .we    (sot_we),
    .waddr (sot_waddr),
    .wdata (sot_wdata),
    .raddr (tag_r),
    .rdata (sot_rdata)
  );

endmodule
